>>> hw/rtl/uud_pkg.sv
`timescale 1ns / 1ps

package uud_pkg;

    // Sizes
    localparam int NAME_MAX   = 15;
    localparam int NAME_W     = $clog2(NAME_MAX + 1);
    localparam int COUNT_BITS = 32;
    localparam int TOTAL_W    = 32;
    localparam int MAX_RES    = 3;
    localparam int STEPS      = 4;

    // Decoder phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_MODE    = 3'd1;
    localparam logic [2:0] PH_NAME    = 3'd2;
    localparam logic [2:0] PH_HDRSKIP = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Characters of interest
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_E     = 8'h65;
    localparam logic [7:0] C_N     = 8'h6E;
    localparam logic [7:0] C_D     = 8'h64;

    // Length of the "begin " header keyword
    localparam logic [2:0] BEGIN_LEN = 3'd6;

    // Position within the current data line
    typedef struct packed {
        logic       at_ls;
        logic [5:0] left;
        logic [1:0] gp;
        logic [5:0] prev;
    } t_line;

    // Outcome of feeding one character to a data line
    typedef struct packed {
        t_line      st;
        logic       emit;
        logic [7:0] data;
    } t_step;

    // One result item as held in the output buffer
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         value;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_res;

    // Characters of "begin " by position.
    function automatic logic [7:0] f_begin_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h67;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h6E;
            default: ch = C_SPACE;
        endcase
        return ch;
    endfunction

    // Characters held while a line may still spell "end" CR LF.
    function automatic logic [7:0] f_held_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = C_N;
            2'd1:    ch = C_D;
            default: ch = C_CR;
        endcase
        return ch;
    endfunction

    // Subtracting 0x20 modulo 64 only flips bit 5.
    function automatic logic [5:0] f_sextet(input logic [7:0] ch);
        return {~ch[5], ch[4:0]};
    endfunction

    // One character of a data line: a byte comes out once its second
    // sextet is in, and only while the line still has bytes to give.
    function automatic t_step f_data_char(input t_line st, input logic [7:0] ch);
        t_step      r;
        logic [5:0] sx;
        r      = '0;
        r.st   = st;
        sx     = f_sextet(ch);
        if (ch == C_LF) begin
            r.st.at_ls = 1'b1;
            r.st.gp    = 2'd0;
            r.st.left  = 6'd0;
        end else if (st.left != 6'd0) begin
            case (st.gp)
                2'd0: begin
                    r.st.gp = 2'd1;
                end
                2'd1: begin
                    r.emit  = 1'b1;
                    r.data  = {st.prev, sx[5:4]};
                    r.st.gp = 2'd2;
                end
                2'd2: begin
                    r.emit  = 1'b1;
                    r.data  = {st.prev[3:0], sx[5:2]};
                    r.st.gp = 2'd3;
                end
                default: begin
                    r.emit  = 1'b1;
                    r.data  = {st.prev[1:0], sx};
                    r.st.gp = 2'd0;
                end
            endcase
            if (r.emit) begin
                r.st.left = st.left - 6'd1;
            end
            r.st.prev = sx;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/uud_in_if.sv
`timescale 1ns / 1ps

// Character stream into the decoder.
interface uud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

>>> hw/rtl/uud_out_if.sv
`timescale 1ns / 1ps

// Result stream out of the decoder.
interface uud_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [7:0]                  value;
    logic [uud_pkg::TOTAL_W-1:0] total_bytes;
    logic                        last;

    modport source (output valid, output kind, output value, output total_bytes,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input total_bytes,
                    input last, output ready);
endinterface

>>> hw/rtl/uuencode_stream_decoder.sv
`timescale 1ns / 1ps

// Streaming uudecoder. Each transfer on i_char carries one text character; the
// block finds the "begin " line, reports the file name characters, then
// reports every decoded data byte with the running byte count, and a single
// finished result on an "end" line or a zero length line, after which it
// ignores input until reset. A character enters an input register and is
// decoded from there into a three-entry result buffer, from which the results
// of the character are presented on o_res. The block takes one character per
// cycle as long as each character yields at most one result and the sink is
// ready; the result buffer drains one result per cycle while the sink is ready,
// so a character that yields several results (up to three, when a line
// beginning with 'e' turns out not to be "end") holds back the next character
// until its last result leaves.
module uuencode_stream_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    uud_in_if.sink    i_char,
    uud_out_if.source o_res
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;

    // Decoder state
    logic [2:0]                     r_phase,     n_phase;
    logic [2:0]                     r_hdr_match, n_hdr_match;
    uud_pkg::t_line                 r_line,      n_line;
    logic [2:0]                     r_end_match, n_end_match;
    logic [uud_pkg::NAME_W-1:0]     r_name_len,  n_name_len;
    logic [uud_pkg::COUNT_BITS-1:0] r_total,     n_total;

    // Result buffer
    uud_pkg::t_res r_res [uud_pkg::MAX_RES];
    logic [1:0]    r_cnt;

    // Decode intermediates
    logic                           w_pop;
    logic                           w_advance;
    logic [7:0]                     w_c;
    logic [5:0]                     w_sx;
    logic [uud_pkg::STEPS-1:0]      w_step_en;
    logic [uud_pkg::STEPS-1:0]      w_emit;
    logic [7:0]                     w_byte [uud_pkg::STEPS];
    uud_pkg::t_line                 w_st;
    uud_pkg::t_step                 w_stp;
    logic [7:0]                     w_step_char;
    logic                           w_single;
    logic [1:0]                     w_single_kind;
    logic [7:0]                     w_single_val;
    logic [uud_pkg::COUNT_BITS-1:0] w_inc [uud_pkg::STEPS];
    uud_pkg::t_res                  w_new [uud_pkg::MAX_RES];
    logic [2:0]                     w_nres;

    localparam logic [uud_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

    // Handshake: the input register moves on when the result buffer is empty
    // or its last entry leaves in the same cycle.
    assign w_pop        = (r_cnt != 2'd0) && o_res.ready;
    assign w_advance    = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_pop));
    assign i_char.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_in;
        end
    end

    assign w_c  = r_in_char;
    assign w_sx = uud_pkg::f_sextet(r_in_char);

    // Phase logic: header search, mode, name, and the start and "end" checks
    // of data lines. Ordinary data characters go through the line steps below.
    always_comb begin
        n_phase       = r_phase;
        n_hdr_match   = r_hdr_match;
        n_end_match   = r_end_match;
        n_name_len    = r_name_len;
        w_st          = r_line;
        w_step_en     = '0;
        w_single      = 1'b0;
        w_single_kind = uud_pkg::KIND_DATA;
        w_single_val  = 8'd0;
        case (r_phase)
            uud_pkg::PH_HEADER: begin
                if (w_c == uud_pkg::C_LF) begin
                    w_st.at_ls  = 1'b1;
                    n_hdr_match = 3'd0;
                end else if (r_line.at_ls && (r_hdr_match < uud_pkg::BEGIN_LEN) &&
                             (w_c == uud_pkg::f_begin_char(r_hdr_match))) begin
                    if (r_hdr_match == uud_pkg::BEGIN_LEN - 3'd1) begin
                        n_phase     = uud_pkg::PH_MODE;
                        n_hdr_match = 3'd0;
                    end else begin
                        n_hdr_match = r_hdr_match + 3'd1;
                    end
                end else begin
                    w_st.at_ls  = 1'b0;
                    n_hdr_match = 3'd0;
                end
            end
            uud_pkg::PH_MODE: begin
                if (w_c == uud_pkg::C_LF) begin
                    n_phase    = uud_pkg::PH_DATA;
                    w_st.at_ls = 1'b1;
                    w_st.left  = 6'd0;
                    w_st.gp    = 2'd0;
                end else if (w_c == uud_pkg::C_SPACE) begin
                    n_phase = uud_pkg::PH_NAME;
                end
            end
            uud_pkg::PH_NAME: begin
                if (w_c == uud_pkg::C_LF) begin
                    n_phase    = uud_pkg::PH_DATA;
                    w_st.at_ls = 1'b1;
                    w_st.left  = 6'd0;
                    w_st.gp    = 2'd0;
                end else if (w_c == uud_pkg::C_CR) begin
                    n_phase = uud_pkg::PH_HDRSKIP;
                end else begin
                    w_single      = 1'b1;
                    w_single_kind = uud_pkg::KIND_NAME;
                    w_single_val  = w_c;
                    n_name_len    = r_name_len + uud_pkg::NAME_W'(1);
                    if (r_name_len >= uud_pkg::NAME_W'(uud_pkg::NAME_MAX - 1)) begin
                        n_phase = uud_pkg::PH_HDRSKIP;
                    end
                end
            end
            uud_pkg::PH_HDRSKIP: begin
                if (w_c == uud_pkg::C_LF) begin
                    n_phase    = uud_pkg::PH_DATA;
                    w_st.at_ls = 1'b1;
                    w_st.left  = 6'd0;
                    w_st.gp    = 2'd0;
                end
            end
            uud_pkg::PH_DATA: begin
                if (r_end_match != 3'd0) begin
                    // Line began with 'e': check for "end" LF or "end" CR LF.
                    if ((r_end_match >= 3'd3) && (w_c == uud_pkg::C_LF)) begin
                        n_end_match   = 3'd0;
                        n_phase       = uud_pkg::PH_DONE;
                        w_single      = 1'b1;
                        w_single_kind = uud_pkg::KIND_DONE;
                    end else if (((r_end_match == 3'd1) && (w_c == uud_pkg::C_N)) ||
                                 ((r_end_match == 3'd2) && (w_c == uud_pkg::C_D)) ||
                                 ((r_end_match == 3'd3) && (w_c == uud_pkg::C_CR))) begin
                        n_end_match = r_end_match + 3'd1;
                    end else begin
                        // Not "end": replay the held characters, then this one.
                        n_end_match  = 3'd0;
                        w_step_en[0] = (r_end_match >= 3'd2);
                        w_step_en[1] = (r_end_match >= 3'd3);
                        w_step_en[2] = (r_end_match >= 3'd4);
                        w_step_en[3] = 1'b1;
                    end
                end else if (r_line.at_ls) begin
                    if (w_c != uud_pkg::C_LF) begin
                        if (w_sx == 6'd0) begin
                            n_phase       = uud_pkg::PH_DONE;
                            w_single      = 1'b1;
                            w_single_kind = uud_pkg::KIND_DONE;
                        end else begin
                            w_st.left  = w_sx;
                            w_st.at_ls = 1'b0;
                            w_st.gp    = 2'd0;
                            if (w_c == uud_pkg::C_E) begin
                                n_end_match = 3'd1;
                            end
                        end
                    end
                end else begin
                    w_step_en[3] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Data line steps: up to three held characters and the current one.
        w_emit = '0;
        for (int i = 0; i < uud_pkg::STEPS; i++) begin
            w_byte[i] = 8'd0;
            if (i < uud_pkg::STEPS - 1) begin
                w_step_char = uud_pkg::f_held_char(2'(i));
            end else begin
                w_step_char = w_c;
            end
            w_stp = uud_pkg::f_data_char(w_st, w_step_char);
            if (w_step_en[i]) begin
                w_st      = w_stp.st;
                w_emit[i] = w_stp.emit;
                w_byte[i] = w_stp.data;
            end
        end
        n_line = w_st;
    end

    // Saturated byte counts for zero, one, two and three new bytes.
    always_comb begin
        for (int j = 0; j < uud_pkg::STEPS; j++) begin
            if (r_total > CNT_MAX - uud_pkg::COUNT_BITS'(j)) begin
                w_inc[j] = CNT_MAX;
            end else begin
                w_inc[j] = r_total + uud_pkg::COUNT_BITS'(j);
            end
        end
    end

    // Pack the results of this character in order and mark the final one.
    always_comb begin
        w_nres = 3'd0;
        for (int k = 0; k < uud_pkg::MAX_RES; k++) begin
            w_new[k] = '0;
        end
        if (w_single) begin
            w_new[0].kind  = w_single_kind;
            w_new[0].value = w_single_val;
            w_new[0].total = uud_pkg::TOTAL_W'(r_total);
            w_nres         = 3'd1;
        end else begin
            for (int i = 0; i < uud_pkg::STEPS; i++) begin
                if (w_emit[i] && (w_nres < 3'(uud_pkg::MAX_RES))) begin
                    w_new[w_nres[1:0]].kind  = uud_pkg::KIND_DATA;
                    w_new[w_nres[1:0]].value = w_byte[i];
                    w_new[w_nres[1:0]].total =
                        uud_pkg::TOTAL_W'(w_inc[w_nres[1:0] + 2'd1]);
                    w_nres = w_nres + 3'd1;
                end
            end
        end
        if (w_nres != 3'd0) begin
            w_new[w_nres[1:0] - 2'd1].last = 1'b1;
        end
        if (w_single || (w_nres == 3'd0)) begin
            n_total = r_total;
        end else begin
            n_total = w_inc[w_nres[1:0]];
        end
    end

    // Decoder state advances with each character leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uud_pkg::PH_HEADER;
            r_hdr_match <= 3'd0;
            r_line      <= '{at_ls: 1'b1, left: 6'd0, gp: 2'd0, prev: 6'd0};
            r_end_match <= 3'd0;
            r_name_len  <= '0;
            r_total     <= '0;
        end else if (w_advance) begin
            r_phase     <= n_phase;
            r_hdr_match <= n_hdr_match;
            r_line      <= n_line;
            r_end_match <= n_end_match;
            r_name_len  <= n_name_len;
            r_total     <= n_total;
        end
    end

    // Result buffer occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_advance) begin
            r_cnt <= w_nres[1:0];
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result buffer contents: load on a new character, shift on a transfer.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_new;
        end else if (w_pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_res.valid       = (r_cnt != 2'd0);
    assign o_res.kind        = r_res[0].kind;
    assign o_res.value       = r_res[0].value;
    assign o_res.total_bytes = r_res[0].total;
    assign o_res.last        = r_res[0].last;

    // Once finished, the decoder stays finished until reset.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == uud_pkg::PH_DONE |=> r_phase == uud_pkg::PH_DONE)
        else $error("decoder left the finished phase");

    // The head of the buffer is the final result exactly when it is the only one.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> (r_res[0].last == (r_cnt == 2'd1)))
        else $error("last flag out of step with buffered results");

    // An "end" check in progress only exists on data lines.
    a_end_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_match != 3'd0 |-> (r_phase == uud_pkg::PH_DATA) && !r_line.at_ls)
        else $error("end check outside a data line");

    // The byte count never goes backwards.
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_total >= $past(r_total))
        else $error("byte count decreased");

endmodule
